>>> rtl/mrfdr_pkg.sv
// ----------------------------------------------------------------------------
// mrfdr_pkg
// Shared types and constants for the multi-reader frame descriptor ring.
// ----------------------------------------------------------------------------
package mrfdr_pkg;

  localparam int RING_DEPTH   = 256;
  localparam int READER_COUNT = 8;
  localparam int OFFSET_BITS  = 24;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int DESC_AW      = RING_AW + 1;
  localparam int RDR_W        = $clog2(READER_COUNT);
  // offset plus length needs one bit more than an offset
  localparam int WRAP_BITS    = OFFSET_BITS + 1;
  localparam int WRAP_CW      = $clog2(WRAP_BITS);

  localparam logic [23:0] BUFFER_LEN_RST     = 24'd1048576;
  localparam logic [15:0] DROP_THRESHOLD_RST = 16'd64;

  localparam logic [2:0] FUNC_PUT   = 3'd0;
  localparam logic [2:0] FUNC_GET   = 3'd1;
  localparam logic [2:0] FUNC_REG   = 3'd2;
  localparam logic [2:0] FUNC_UNREG = 3'd3;
  localparam logic [2:0] FUNC_STAT  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_BUFFER_LEN     = 1'b0;
  localparam logic CFG_DROP_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [23:0] offset;
    logic [23:0] length;
    logic [31:0] seconds;
    logic [19:0] micro;
  } desc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DROP,
    S_WRITE,
    S_WRAP,
    S_READ,
    S_DONE
  } state_t;

endpackage

>>> rtl/multi_reader_frame_descriptor_ring.sv
// ----------------------------------------------------------------------------
// multi_reader_frame_descriptor_ring
// Two descriptor rings (video, audio) shared by up to eight readers.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         func reader stream length seconds microseconds
//  result    done (strobe)        status stream_out offset_out length_out
//                                 seconds_out microseconds_out video_backlog
//                                 audio_backlog skipped_frames
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// Descriptors live in one synchronous RAM (registered read). Counts and
// reader flags are flip-flops. Slowest-reader search walks one reader per
// cycle. A video put runs one scan per drop pass (up to READER_COUNT+1
// scans). The fill offset wrap is a restoring remainder, one bit per cycle.
// Reset is synchronous and clears all counts; the RAM is not cleared.
// Config is taken only while idle. Results cannot be stalled.
// ----------------------------------------------------------------------------
module multi_reader_frame_descriptor_ring
  import mrfdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [2:0]  reader,
  input  logic        stream,
  input  logic [23:0] length,
  input  logic [31:0] seconds,
  input  logic [19:0] microseconds,
  output logic        done,
  output logic [1:0]  status,
  output logic        stream_out,
  output logic [23:0] offset_out,
  output logic [23:0] length_out,
  output logic [31:0] seconds_out,
  output logic [19:0] microseconds_out,
  output logic [31:0] video_backlog,
  output logic [31:0] audio_backlog,
  output logic [31:0] skipped_frames,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  state_t state, state_next;

  logic [23:0] buffer_len;
  logic [15:0] drop_threshold;

  logic [31:0] write_counts [2];
  logic [31:0] read_counts  [2][READER_COUNT];
  logic [READER_COUNT-1:0] reader_active;
  logic [23:0] fill_offset;

  // latched command
  logic [2:0]  c_func;
  logic [2:0]  c_reader;
  logic        c_stream;
  desc_t       c_desc;

  // scan
  logic [RDR_W-1:0] scan_idx;
  logic             scan_ring;
  logic             best_ok;
  logic [RDR_W-1:0] best_r;
  logic [31:0]      best_lag;
  logic [RDR_W:0]   pass_cnt;
  logic [31:0]      skipped;

  // fill offset remainder
  logic [WRAP_BITS-1:0] wrap_acc;
  logic [23:0]          wrap_rem;
  logic [WRAP_CW-1:0]   wrap_cnt;

  // get outcome, captured when the RAM read is issued
  logic get_hit, get_s;

  // RAM
  logic               ram_we;
  logic [DESC_AW-1:0] ram_waddr, ram_raddr;
  desc_t              ram_rdata;

  mrfdr_desc_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (c_desc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config only between transactions, so no operation sees a change midway
  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  logic [RDR_W-1:0]     cur_r;
  logic [31:0]          cur_lag;
  logic [15:0]          thr;
  logic [24:0]          blen;
  logic                 rdr_ok;
  logic [31:0]          g_vl, g_al;
  logic                 g_vw, g_aw, g_s;
  logic [WRAP_BITS-1:0] wrap_sh, wrap_sub;

  always_comb begin
    cur_r   = scan_idx;
    cur_lag = write_counts[scan_ring] - read_counts[scan_ring][cur_r];
    thr     = (drop_threshold == 16'd0) ? 16'd1 : drop_threshold;
    blen    = (buffer_len == 24'd0) ? 25'h1000000 : {1'b0, buffer_len};
    rdr_ok  = ({1'b0, c_reader} < (RDR_W+1)'(READER_COUNT));
    g_vl    = write_counts[0] - read_counts[0][c_reader[RDR_W-1:0]];
    g_al    = write_counts[1] - read_counts[1][c_reader[RDR_W-1:0]];
    g_vw    = (g_vl != 32'd0) && !g_vl[31];
    g_aw    = (g_al != 32'd0) && !g_al[31];
    g_s     = g_aw;
    // one restoring step: bring in the next dividend bit, subtract if it fits
    wrap_sh  = {wrap_rem, wrap_acc[WRAP_BITS-1]};
    wrap_sub = (wrap_sh >= blen) ? (wrap_sh - blen) : wrap_sh;
    ram_we    = (state == S_WRITE);
    ram_waddr = {c_stream, write_counts[c_stream][RING_AW-1:0]};
    ram_raddr = {g_s, read_counts[g_s][c_reader[RDR_W-1:0]][RING_AW-1:0]};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (func == FUNC_PUT && length != 24'd0 && stream == 1'b0) begin
            state_next = S_SCAN;
          end else if (func == FUNC_PUT && length != 24'd0) begin
            state_next = S_WRITE;
          end else if (func == FUNC_STAT) begin
            state_next = S_SCAN;
          end else if (func == FUNC_GET) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx == RDR_W'(READER_COUNT - 1)) begin
          if (c_func == FUNC_STAT) begin
            state_next = scan_ring ? S_DONE : S_SCAN;
          end else begin
            state_next = S_DROP;
          end
        end
      end
      S_DROP: begin
        if (!best_ok || best_lag < {16'd0, thr} ||
            pass_cnt == (RDR_W+1)'(READER_COUNT)) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_WRITE: state_next = S_WRAP;
      S_WRAP:  if (wrap_cnt == WRAP_CW'(WRAP_BITS - 1)) state_next = S_DONE;
      S_READ:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic l_best_ok;
  logic [RDR_W-1:0] l_best_r;
  logic [31:0] l_best_lag;
  always_comb begin
    l_best_ok  = best_ok;
    l_best_r   = best_r;
    l_best_lag = best_lag;
    if (reader_active[cur_r] && (!best_ok || cur_lag > best_lag)) begin
      l_best_ok  = 1'b1;
      l_best_r   = cur_r;
      l_best_lag = cur_lag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_len     <= BUFFER_LEN_RST;
      drop_threshold <= DROP_THRESHOLD_RST;
      write_counts   <= '{default: '0};
      read_counts    <= '{default: '{default: '0}};
      reader_active  <= '0;
      fill_offset    <= '0;
      done           <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BUFFER_LEN:     buffer_len     <= cfg_data;
          CFG_DROP_THRESHOLD: drop_threshold <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            c_func   <= func;
            c_reader <= reader;
            c_stream <= stream;
            c_desc   <= '{offset: fill_offset, length: length,
                          seconds: seconds, micro: microseconds};
            scan_idx <= '0;
            scan_ring <= 1'b0;
            best_ok  <= 1'b0;
            best_lag <= '0;
            best_r   <= '0;
            pass_cnt <= '0;
            skipped  <= '0;
            status     <= ST_OK;
            stream_out <= 1'b0;
            offset_out <= '0;
            length_out <= '0;
            seconds_out <= '0;
            microseconds_out <= '0;
            video_backlog <= '0;
            audio_backlog <= '0;
            skipped_frames <= '0;
          end
        end
        S_SCAN: begin
          if (scan_idx == RDR_W'(READER_COUNT - 1)) begin
            scan_idx <= '0;
            if (c_func == FUNC_STAT) begin
              if (!scan_ring) video_backlog <= l_best_ok ? l_best_lag : 32'd0;
              else            audio_backlog <= l_best_ok ? l_best_lag : 32'd0;
              scan_ring <= 1'b1;
              best_ok   <= 1'b0;
              best_lag  <= '0;
            end else begin
              best_ok  <= l_best_ok;
              best_r   <= l_best_r;
              best_lag <= l_best_lag;
            end
          end else begin
            scan_idx <= scan_idx + 1'b1;
            best_ok  <= l_best_ok;
            best_r   <= l_best_r;
            best_lag <= l_best_lag;
          end
        end
        S_DROP: begin
          if (best_ok && best_lag >= {16'd0, thr} && pass_cnt != (RDR_W+1)'(READER_COUNT)) begin
            skipped <= skipped + best_lag;
            read_counts[0][best_r] <= write_counts[0];
            pass_cnt <= pass_cnt + 1'b1;
          end
          best_ok  <= 1'b0;
          best_lag <= '0;
        end
        S_WRITE: begin
          wrap_acc <= {1'b0, fill_offset} + {1'b0, c_desc.length};
          wrap_rem <= '0;
          wrap_cnt <= '0;
          write_counts[c_stream] <= write_counts[c_stream] + 32'd1;
          stream_out     <= c_stream;
          offset_out     <= c_desc.offset;
          length_out     <= c_desc.length;
          skipped_frames <= skipped;
        end
        S_WRAP: begin
          // (offset + length) mod buffer length, MSB first
          wrap_acc <= {wrap_acc[WRAP_BITS-2:0], 1'b0};
          wrap_rem <= wrap_sub[23:0];
          wrap_cnt <= wrap_cnt + 1'b1;
          if (wrap_cnt == WRAP_CW'(WRAP_BITS - 1)) begin
            fill_offset <= wrap_sub[23:0];
          end
        end
        S_READ: begin
          get_hit <= rdr_ok && (g_vw || g_aw);
          get_s   <= g_s;
          if (rdr_ok && (g_vw || g_aw)) begin
            read_counts[g_s][c_reader[RDR_W-1:0]] <=
              read_counts[g_s][c_reader[RDR_W-1:0]] + 32'd1;
          end
        end
        S_DONE: begin
          case (c_func)
            FUNC_PUT: begin
              if (c_desc.length == 24'd0) status <= ST_BAD;
            end
            FUNC_STAT: ;
            FUNC_GET: begin
              // RAM data for the read issued in S_READ is valid here
              if (!rdr_ok) begin
                status <= ST_BAD;
              end else if (!get_hit) begin
                status <= ST_EMPTY;
              end else begin
                stream_out       <= get_s;
                offset_out       <= ram_rdata.offset;
                length_out       <= ram_rdata.length;
                seconds_out      <= ram_rdata.seconds;
                microseconds_out <= ram_rdata.micro;
              end
            end
            FUNC_REG: begin
              if (!rdr_ok) begin
                status <= ST_BAD;
              end else begin
                if (reader_active == '0) begin
                  write_counts <= '{default: '0};
                  read_counts  <= '{default: '{default: '0}};
                  fill_offset  <= '0;
                end else begin
                  read_counts[0][c_reader[RDR_W-1:0]] <= write_counts[0];
                  read_counts[1][c_reader[RDR_W-1:0]] <= write_counts[1];
                end
                reader_active[c_reader[RDR_W-1:0]] <= 1'b1;
              end
            end
            FUNC_UNREG: begin
              if (!rdr_ok) begin
                status <= ST_BAD;
              end else begin
                reader_active[c_reader[RDR_W-1:0]] <= 1'b0;
                read_counts[0][c_reader[RDR_W-1:0]] <= '0;
                read_counts[1][c_reader[RDR_W-1:0]] <= '0;
              end
            end
            default: status <= ST_BAD;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mrfdr_desc_ram.sv
// ----------------------------------------------------------------------------
// mrfdr_desc_ram
// Descriptor memory for both rings, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrfdr_desc_ram
  import mrfdr_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [DESC_AW-1:0] waddr,
  input  desc_t              wdata,
  input  logic [DESC_AW-1:0] raddr,
  output desc_t              rdata
);

  desc_t mem [2*RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
